>>> hw/rtl/tofs_pkg.sv
// ----------------------------------------------------------------------------
// tofs_pkg
// shared types and constants of the timed order ack / fill simulator
// ----------------------------------------------------------------------------
package tofs_pkg;

  localparam logic [31:0] DEFAULT_SEED = 32'd2463534242;
  localparam logic [16:0] RATIO_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POLL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NEW_ACK    = 3'd0,
    KIND_REJECT     = 3'd1,
    KIND_FILL       = 3'd2,
    KIND_PARTIAL    = 3'd3,
    KIND_CANCEL_ACK = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_ACK_LAT    = 3'd0,
    REG_FILL_LAT   = 3'd1,
    REG_CANCEL_LAT = 3'd2,
    REG_REJECT_TH  = 3'd3,
    REG_FILL_TH    = 3'd4,
    REG_RATIO      = 3'd5,
    REG_SEED       = 3'd6,
    REG_SPARE      = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] now_time;
    logic [63:0] order_ident;
    logic [31:0] order_price;
    logic [31:0] order_quantity;
  } in_beat_t;

  typedef struct packed {
    logic        report_valid;
    logic        accepted;
    logic [63:0] report_ident;
    logic [2:0]  report_kind;
    logic [31:0] fill_price_out;
    logic [31:0] filled_quantity;
    logic [31:0] leaves_quantity;
    logic [63:0] report_time;
    logic [4:0]  active_count;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] ident;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [63:0] ack_due;
    logic [63:0] fill_due;
  } slot_t;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

>>> hw/rtl/tofs_ram.sv
// ----------------------------------------------------------------------------
// tofs_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module tofs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/timed_order_ack_fill_simulator_top.sv
// ----------------------------------------------------------------------------
// timed_order_ack_fill_simulator_top
// simulated exchange with a table of pending order and cancel slots
// ----------------------------------------------------------------------------
// Each beat is handled alone. A new order or cancel scans the active flags one
// slot a cycle to find the first free slot, then writes it. A poll walks the
// slots in order, skipping inactive ones, and reads each active candidate from
// the slot ram through the scan, read and evaluate states, with a multiply
// state for a partial fill product. The result is held in an output register
// until taken; the next beat is accepted after.
module timed_order_ack_fill_simulator_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tofs_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tofs_pkg::out_beat_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import tofs_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int SW = $bits(slot_t);

  logic [31:0] ack_lat_r, fill_lat_r, cancel_lat_r, reject_th_r, fill_th_r, seed_r;
  logic [16:0] ratio_r;
  logic [31:0] rnd_r, rnd_nxt;

  logic [SLOT_COUNT-1:0] act_r, acked_r, iscan_r;
  logic [CW-1:0]         cnt_r;

  state_t    state_r, state_nxt;
  in_beat_t  in_r;
  out_beat_t out_r;
  logic      out_valid_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] ix;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata, ram_rdata;
  logic [63:0]   mul_r;

  reg_t wreg;
  logic cfg_wr;

  assign ix = idx_r[IW-1:0];
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign wreg = reg_t'(cfg_paddr[4:2]);

  tofs_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ix),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (wreg)
      REG_ACK_LAT:    cfg_prdata = ack_lat_r;
      REG_FILL_LAT:   cfg_prdata = fill_lat_r;
      REG_CANCEL_LAT: cfg_prdata = cancel_lat_r;
      REG_REJECT_TH:  cfg_prdata = reject_th_r;
      REG_FILL_TH:    cfg_prdata = fill_th_r;
      REG_RATIO:      cfg_prdata = {15'd0, ratio_r};
      REG_SEED:       cfg_prdata = seed_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // evaluation of the slot just read
  logic        past_ack, past_fill, rej_draw, fill_on, drop, part_try;
  logic [31:0] r1, r2, qty, fq;
  logic [16:0] ratio_c;
  logic        scan_end, is_submit;

  assign is_submit = (in_r.operation == OP_NEW) || (in_r.operation == OP_CANCEL);
  assign scan_end  = (idx_r == CW'(SLOT_COUNT - 1));
  assign past_ack  = in_r.now_time >= ram_rdata.ack_due;
  assign past_fill = in_r.now_time >= ram_rdata.fill_due;
  assign r1        = xorshift(rnd_r);
  assign r2        = xorshift(r1);
  assign rej_draw  = (reject_th_r != '0);
  assign fill_on   = (fill_th_r != '1);
  assign drop      = fill_on && (r1 >= fill_th_r);
  assign part_try  = (ratio_r != '0) && ((fill_on ? r2 : r1) < 32'h8000_0000);
  assign ratio_c   = (ratio_r > RATIO_ONE) ? RATIO_ONE : ratio_r;
  assign qty       = ram_rdata.quantity;
  assign fq        = (mul_r[47:16] == '0) ? 32'd1 : mul_r[47:16];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (is_submit) begin
          if (!act_r[ix] || scan_end) state_nxt = ST_DONE;
        end else if (in_r.operation != OP_POLL) begin
          state_nxt = ST_DONE;
        end else if (act_r[ix]) begin
          state_nxt = ST_READ;
        end else if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!past_ack) begin
          state_nxt = scan_end ? ST_DONE : ST_SCAN;
        end else if (iscan_r[ix] || !acked_r[ix]) begin
          state_nxt = ST_DONE;
        end else if (!past_fill || drop) begin
          state_nxt = scan_end ? ST_DONE : ST_SCAN;
        end else if (part_try) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
    out_data.active_count = 5'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ack_lat_r    <= '0;
      fill_lat_r   <= '0;
      cancel_lat_r <= '0;
      reject_th_r  <= '0;
      fill_th_r    <= '1;
      ratio_r      <= '0;
      seed_r       <= DEFAULT_SEED;
      rnd_r        <= DEFAULT_SEED;
      act_r        <= '0;
      acked_r      <= '0;
      iscan_r      <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      if (cfg_wr) begin
        unique case (wreg)
          REG_ACK_LAT:    ack_lat_r    <= cfg_pwdata;
          REG_FILL_LAT:   fill_lat_r   <= cfg_pwdata;
          REG_CANCEL_LAT: cancel_lat_r <= cfg_pwdata;
          REG_REJECT_TH:  reject_th_r  <= cfg_pwdata;
          REG_FILL_TH:    fill_th_r    <= cfg_pwdata;
          REG_RATIO:      ratio_r      <= cfg_pwdata[16:0];
          REG_SEED:       seed_r       <= cfg_pwdata;
          default:        ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            out_r <= '0;
          end
        end
        ST_SCAN: begin
          if (is_submit) begin
            if (!act_r[ix]) begin
              act_r[ix]   <= 1'b1;
              acked_r[ix] <= 1'b0;
              iscan_r[ix] <= (in_r.operation == OP_CANCEL);
              cnt_r       <= cnt_r + 1'b1;
              out_r.accepted <= 1'b1;
            end
            if (!act_r[ix] || scan_end) out_valid_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end else if (in_r.operation != OP_POLL) begin
            out_valid_r <= 1'b1;
          end else if (!act_r[ix]) begin
            if (scan_end) out_valid_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end
        end
        ST_EVAL: begin
          if (past_ack && (iscan_r[ix] || !acked_r[ix] || (past_fill && !drop))) begin
            out_r.report_ident <= ram_rdata.ident;
            out_r.report_time  <= in_r.now_time;
          end
          if (!past_ack) begin
            if (scan_end) out_valid_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end else if (iscan_r[ix]) begin
            out_r.report_valid <= 1'b1;
            out_r.report_kind  <= KIND_CANCEL_ACK;
            act_r[ix] <= 1'b0;
            cnt_r <= cnt_r - 1'b1;
            out_valid_r <= 1'b1;
          end else if (!acked_r[ix]) begin
            out_r.report_valid    <= 1'b1;
            out_r.leaves_quantity <= qty;
            out_valid_r <= 1'b1;
            if (rej_draw && r1 < reject_th_r) begin
              out_r.report_kind <= KIND_REJECT;
              act_r[ix] <= 1'b0;
              cnt_r <= cnt_r - 1'b1;
            end else begin
              out_r.report_kind <= KIND_NEW_ACK;
              acked_r[ix] <= 1'b1;
            end
          end else if (!past_fill) begin
            if (scan_end) out_valid_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end else if (drop) begin
            act_r[ix] <= 1'b0;
            cnt_r <= cnt_r - 1'b1;
            if (scan_end) out_valid_r <= 1'b1;
            else idx_r <= idx_r + 1'b1;
          end else if (part_try) begin
            mul_r <= 64'(qty) * 64'(ratio_c);
          end else begin
            out_r.report_valid    <= 1'b1;
            out_r.report_kind     <= KIND_FILL;
            out_r.fill_price_out  <= ram_rdata.price;
            out_r.filled_quantity <= qty;
            act_r[ix] <= 1'b0;
            cnt_r <= cnt_r - 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        ST_MUL: begin
          out_r.report_valid    <= 1'b1;
          out_r.fill_price_out  <= ram_rdata.price;
          out_r.filled_quantity <= fq;
          out_valid_r <= 1'b1;
          if (fq >= qty) begin
            out_r.report_kind <= KIND_FILL;
            act_r[ix] <= 1'b0;
            cnt_r <= cnt_r - 1'b1;
          end else begin
            out_r.report_kind     <= KIND_PARTIAL;
            out_r.leaves_quantity <= qty - fq;
          end
        end
        ST_DONE: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) in_r <= in_data;
  end

  // random word advances in the evaluate state by the number of draws made
  always_comb begin
    rnd_nxt = rnd_r;
    if (cfg_wr && wreg == REG_SEED) begin
      rnd_nxt = (cfg_pwdata != '0) ? cfg_pwdata : DEFAULT_SEED;
    end else if (state_r == ST_EVAL && past_ack && !iscan_r[ix]) begin
      if (!acked_r[ix]) begin
        if (rej_draw) rnd_nxt = r1;
      end else if (past_fill) begin
        if (fill_on && drop) rnd_nxt = r1;
        else if (fill_on && ratio_r != '0) rnd_nxt = r2;
        else if (fill_on || ratio_r != '0) rnd_nxt = r1;
      end
    end
  end

  // slot ram write: submit stores the entry, partial fill updates it
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ix;
    ram_wdata = ram_rdata;
    if (state_r == ST_SCAN && is_submit && !act_r[ix]) begin
      ram_we = 1'b1;
      ram_wdata.ident = in_r.order_ident;
      if (in_r.operation == OP_NEW) begin
        ram_wdata.price    = in_r.order_price;
        ram_wdata.quantity = in_r.order_quantity;
        ram_wdata.ack_due  = in_r.now_time + {32'd0, ack_lat_r};
        ram_wdata.fill_due = in_r.now_time + {32'd0, fill_lat_r};
      end else begin
        ram_wdata.ack_due  = in_r.now_time + {32'd0, cancel_lat_r};
      end
    end else if (state_r == ST_MUL && fq < qty) begin
      ram_we = 1'b1;
      ram_wdata.quantity = qty - fq;
      ram_wdata.fill_due = in_r.now_time + {32'd0, fill_lat_r};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(act_r)))
    else $error("active count out of step");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_DONE)
    else $error("result shown outside done");
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.report_valid) |-> !out_data.accepted)
    else $error("report and accept together");
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("no return to idle");
endmodule
